>>> hdl/matrix_inverse_3x3_top_assert.svh
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_top_assert
// Assertion macros for the 3x3 inverse block; clock i_clk, reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_3X3_TOP_ASSERT_SVH
`define MATRIX_INVERSE_3X3_TOP_ASSERT_SVH

// same-cycle implication
`define MI3_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared widths, payload types and limits of the 3x3 inverse block.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int W       = 32;
    localparam int FRAC_W  = 16;
    localparam int PW      = 2 * W;
    localparam int CW      = 2 * W + 1;
    localparam int DW      = 3 * W + 3;
    localparam int LAT_COF = 2;
    localparam int LAT_DET = 2;
    localparam int LAT_DIV = W + 3;
    localparam int LAT_TOT = LAT_COF + LAT_DET + LAT_DIV;

    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] HALF = SMIN;

    typedef struct packed {
        logic signed [W-1:0] m00;
        logic signed [W-1:0] m01;
        logic signed [W-1:0] m02;
        logic signed [W-1:0] m10;
        logic signed [W-1:0] m11;
        logic signed [W-1:0] m12;
        logic signed [W-1:0] m20;
        logic signed [W-1:0] m21;
        logic signed [W-1:0] m22;
    } t_mat_in;

    typedef struct packed {
        logic signed [W-1:0] r00;
        logic signed [W-1:0] r01;
        logic signed [W-1:0] r02;
        logic signed [W-1:0] r10;
        logic signed [W-1:0] r11;
        logic signed [W-1:0] r12;
        logic signed [W-1:0] r20;
        logic signed [W-1:0] r21;
        logic signed [W-1:0] r22;
        logic signed [W-1:0] det_out;
        logic                singular;
    } t_mat_out;

endpackage

>>> hdl/mi3_cofactor.sv
// ----------------------------------------------------------------------------
// mi3_cofactor
// Two stages: the eighteen 2x2 minor products, then the nine signed cofactors.
// ----------------------------------------------------------------------------
module mi3_cofactor import mi3_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  t_mat_in             i_mat,
    output logic signed [CW-1:0] o_cof [9],
    output logic signed [W-1:0]  o_row0 [3]
);

    logic signed [W-1:0]  m [9];
    logic signed [PW-1:0] r_pa [9];
    logic signed [PW-1:0] r_pb [9];
    logic signed [W-1:0]  r_row0 [3];
    logic signed [W-1:0]  r_row0_d [3];
    logic signed [CW-1:0] r_cof [9];

    assign m[0] = i_mat.m00;
    assign m[1] = i_mat.m01;
    assign m[2] = i_mat.m02;
    assign m[3] = i_mat.m10;
    assign m[4] = i_mat.m11;
    assign m[5] = i_mat.m12;
    assign m[6] = i_mat.m20;
    assign m[7] = i_mat.m21;
    assign m[8] = i_mat.m22;

    for (genvar rr = 0; rr < 3; rr++) begin : g_row
        for (genvar cc = 0; cc < 3; cc++) begin : g_col
            localparam int R1 = (rr + 1) % 3;
            localparam int R2 = (rr + 2) % 3;
            localparam int C1 = (cc + 1) % 3;
            localparam int C2 = (cc + 2) % 3;
            localparam int IX = rr * 3 + cc;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pa[IX]  <= m[R1*3+C1] * m[R2*3+C2];
                    r_pb[IX]  <= m[R1*3+C2] * m[R2*3+C1];
                    r_cof[IX] <= $signed({r_pa[IX][PW-1], r_pa[IX]})
                               - $signed({r_pb[IX][PW-1], r_pb[IX]});
                end
            end
            assign o_cof[IX] = r_cof[IX];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_row0[rr]   <= m[rr];
                r_row0_d[rr] <= r_row0[rr];
            end
        end
        assign o_row0[rr] = r_row0_d[rr];
    end

endmodule

>>> hdl/mi3_det.sv
// ----------------------------------------------------------------------------
// mi3_det
// Determinant along row 0: split partial products, then the exact sum.
// ----------------------------------------------------------------------------
module mi3_det import mi3_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_cof [9],
    input  logic signed [W-1:0]  i_row0 [3],
    output logic signed [CW-1:0] o_cof [9],
    output logic signed [DW-1:0] o_det
);

    logic signed [2*W:0]  r_lo [3];
    logic signed [2*W:0]  r_hi [3];
    logic signed [CW-1:0] r_cof_a [9];
    logic signed [CW-1:0] r_cof_b [9];
    logic signed [DW-1:0] term [3];
    logic signed [DW-1:0] r_det;

    for (genvar c = 0; c < 3; c++) begin : g_term
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lo[c] <= i_row0[c] * $signed({1'b0, i_cof[c][W-1:0]});
                r_hi[c] <= i_row0[c] * $signed(i_cof[c][CW-1:W]);
            end
        end
        assign term[c] = (DW'(r_hi[c]) <<< W) + DW'(r_lo[c]);
    end

    for (genvar e = 0; e < 9; e++) begin : g_pass
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cof_a[e] <= i_cof[e];
                r_cof_b[e] <= r_cof_a[e];
            end
        end
        assign o_cof[e] = r_cof_b[e];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det <= term[0] + term[1] + term[2];
        end
    end

    assign o_det = r_det;

endmodule

>>> hdl/mi3_div.sv
// ----------------------------------------------------------------------------
// mi3_div
// Pipelined restoring divider: cofactor * 2^(2F) / det, one quotient bit per
// stage, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module mi3_div import mi3_pkg::*; #(
    parameter int FRAC_BITS = FRAC_W
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_num,
    input  logic signed [DW-1:0] i_den,
    output logic signed [W-1:0]  o_q
);

    localparam int NMW = CW + 2 * FRAC_BITS;
    localparam int XW  = DW + W;

    logic [CW-1:0] num_abs;
    logic [DW-1:0] den_abs;
    logic [XW-1:0] r_nmag;
    logic [DW-1:0] r_dmag;
    logic          r_neg_a;

    logic [XW-1:0] r_rem [W];
    logic [DW-1:0] r_d   [W];
    logic [W-1:0]  r_q   [W+1];
    logic          r_neg [W+1];
    logic          r_ovf [W+1];
    logic [W-1:0]  r_out;

    assign num_abs = i_num[CW-1] ? CW'(-i_num) : CW'(i_num);
    assign den_abs = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nmag  <= XW'(NMW'({num_abs, {(2*FRAC_BITS){1'b0}}}));
            r_dmag  <= den_abs;
            r_neg_a <= i_num[CW-1] ^ i_den[DW-1];
            // quotient of more than W bits always saturates
            r_ovf[0] <= r_nmag >= {r_dmag, {W{1'b0}}};
            r_rem[0] <= r_nmag;
            r_d[0]   <= r_dmag;
            r_q[0]   <= '0;
            r_neg[0] <= r_neg_a;
        end
    end

    for (genvar s = 0; s < W; s++) begin : g_it
        localparam int K = W - 1 - s;
        logic [XW-1:0] dsh;
        logic          ge;
        assign dsh = XW'(r_d[s]) << K;
        assign ge  = r_rem[s] >= dsh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s+1]   <= r_q[s] | (W'(ge) << K);
                r_neg[s+1] <= r_neg[s];
                r_ovf[s+1] <= r_ovf[s];
            end
        end
        if (s < W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s+1] <= ge ? r_rem[s] - dsh : r_rem[s];
                    r_d[s+1]   <= r_d[s];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ovf[W]) begin
                r_out <= r_neg[W] ? SMIN : SMAX;
            end else if (r_neg[W]) begin
                r_out <= (r_q[W] > HALF) ? SMIN : W'(-r_q[W]);
            end else begin
                r_out <= (r_q[W] >= HALF) ? SMAX : r_q[W];
            end
        end
    end

    assign o_q = $signed(r_out);

endmodule

>>> hdl/matrix_inverse_3x3_top.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_top
// 3x3 signed fixed-point inverse by adjugate over determinant.
// ----------------------------------------------------------------------------
// Takes one matrix item every cycle while the output does not stall, and
// returns its result item after the cofactor stages, the determinant stages,
// then nine parallel restoring dividers that settle one quotient bit per stage,
// which sets the latency. A stall on the output while a result item is held
// freezes the whole pipeline and is passed back on o_stall in the same cycle.
// ----------------------------------------------------------------------------
`include "matrix_inverse_3x3_top_assert.svh"

module matrix_inverse_3x3_top import mi3_pkg::*; #(
    parameter int FRAC_BITS = FRAC_W
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_mat_in  i_data,
    output logic     o_valid,
    input  logic     i_stall,
    output t_mat_out o_data
);

    typedef struct packed {
        logic         sing;
        logic [W-1:0] dout;
    } t_det_st;

    logic                 en;
    logic [LAT_TOT-1:0]   r_vld;
    logic signed [CW-1:0] cof_a [9];
    logic signed [W-1:0]  row0 [3];
    logic signed [CW-1:0] cof_b [9];
    logic signed [DW-1:0] det;
    logic signed [W-1:0]  q [9];
    logic [DW-1:0]        det_abs;
    logic                 r_sing0;
    logic                 r_dneg;
    logic [DW-1:0]        r_dmag;
    logic [W-1:0]         dout;
    t_det_st              r_st [LAT_DIV-1];

    assign en      = ~(r_vld[LAT_TOT-1] & i_stall);
    assign o_stall = ~en;
    assign o_valid = r_vld[LAT_TOT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT_TOT-2:0], i_valid};
        end
    end

    mi3_cofactor u_cof (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_mat  (i_data),
        .o_cof  (cof_a),
        .o_row0 (row0)
    );

    mi3_det u_det (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_cof  (cof_a),
        .i_row0 (row0),
        .o_cof  (cof_b),
        .o_det  (det)
    );

    // inverse (i,j) is cofactor (j,i) over det
    for (genvar i = 0; i < 3; i++) begin : g_ri
        for (genvar j = 0; j < 3; j++) begin : g_rj
            mi3_div #(.FRAC_BITS(FRAC_BITS)) u_div (
                .i_clk (i_clk),
                .i_en  (en),
                .i_num (cof_b[j*3+i]),
                .i_den (det),
                .o_q   (q[i*3+j])
            );
        end
    end

    assign det_abs = det[DW-1] ? DW'(-det) : DW'(det);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sing0 <= (det == '0);
            r_dneg  <= det[DW-1];
            r_dmag  <= det_abs >> (2 * FRAC_BITS);
        end
    end

    always_comb begin
        if (r_dneg) begin
            dout = (r_dmag > DW'(HALF)) ? SMIN : W'(-r_dmag[W-1:0]);
        end else begin
            dout = (r_dmag >= DW'(HALF)) ? SMAX : r_dmag[W-1:0];
        end
    end

    for (genvar k = 0; k < LAT_DIV - 1; k++) begin : g_st
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (k == 0) begin
                    r_st[k] <= '{sing: r_sing0, dout: dout};
                end else begin
                    r_st[k] <= r_st[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    always_comb begin
        o_data.singular = r_st[LAT_DIV-2].sing;
        o_data.det_out  = r_st[LAT_DIV-2].sing ? '0 : $signed(r_st[LAT_DIV-2].dout);
        o_data.r00 = r_st[LAT_DIV-2].sing ? '0 : q[0];
        o_data.r01 = r_st[LAT_DIV-2].sing ? '0 : q[1];
        o_data.r02 = r_st[LAT_DIV-2].sing ? '0 : q[2];
        o_data.r10 = r_st[LAT_DIV-2].sing ? '0 : q[3];
        o_data.r11 = r_st[LAT_DIV-2].sing ? '0 : q[4];
        o_data.r12 = r_st[LAT_DIV-2].sing ? '0 : q[5];
        o_data.r20 = r_st[LAT_DIV-2].sing ? '0 : q[6];
        o_data.r21 = r_st[LAT_DIV-2].sing ? '0 : q[7];
        o_data.r22 = r_st[LAT_DIV-2].sing ? '0 : q[8];
    end

    `MI3_ASSERT_NOW(a_stall_only_full, o_stall, o_valid, "stall raised with no item held")
    `MI3_ASSERT_NEXT(a_freeze, o_stall, $stable(r_vld), "valid chain moved during stall")
    `MI3_ASSERT_NEXT(a_enter, i_valid && !o_stall, r_vld[0], "accepted item lost at entry")
    `MI3_ASSERT_NOW(a_sing_det, o_valid && o_data.singular, o_data.det_out == '0,
        "singular item with non-zero determinant")

endmodule

>>> bench/mi3_checker.sv
// ----------------------------------------------------------------------------
// mi3_checker
// Result predictor and scoreboard for the 3x3 inverse block.
// ----------------------------------------------------------------------------
// Watches both channels. Each accepted matrix is inverted exactly in wide
// signed arithmetic and the expected item is queued. Each accepted result is
// compared field by field with the oldest queued item.
// ----------------------------------------------------------------------------
module mi3_checker import mi3_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_mat_in  i_in_data,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_mat_out i_out_data,
    output int       o_errors,
    output int       o_pending
);

    typedef logic signed [191:0] t_wide;

    t_mat_out inv_q[$];
    int       errors = 0;
    int       pending = 0;

    assign o_errors  = errors;
    assign o_pending = pending;

    function automatic logic [W-1:0] clamp(t_wide v);
        t_wide hi;
        t_wide lo;
        hi = t_wide'(SMAX);
        lo = -hi - 1;
        if (v > hi) begin
            return SMAX;
        end else if (v < lo) begin
            return SMIN;
        end
        return v[W-1:0];
    endfunction

    function automatic t_mat_out invert(t_mat_in a);
        t_wide    m[9];
        t_wide    adj[9];
        t_wide    det;
        t_mat_out res;
        logic [W*9-1:0] flat;
        int r1, r2, c1, c2;
        flat = a;
        for (int k = 0; k < 9; k++) begin
            m[k] = t_wide'($signed(flat[W*(8-k) +: W]));
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r1 = (r + 1) % 3; r2 = (r + 2) % 3;
                c1 = (c + 1) % 3; c2 = (c + 2) % 3;
                adj[c*3 + r] = m[r1*3 + c1] * m[r2*3 + c2] - m[r1*3 + c2] * m[r2*3 + c1];
            end
        end
        det = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
        res = '0;
        if (det == 0) begin
            res.singular = 1'b1;
            return res;
        end
        flat = '0;
        for (int k = 0; k < 9; k++) begin
            flat[W*(8-k) +: W] = clamp((adj[k] <<< (2 * FRAC_W)) / det);
        end
        res = {flat, clamp(det / (t_wide'(1) <<< (2 * FRAC_W))), 1'b0};
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_mat_out want;
        logic [W-1:0] w_exp, w_got;
        bit bad;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                inv_q.push_back(invert(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                if (inv_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result item %h", i_out_data);
                end else begin
                    want = inv_q.pop_front();
                    bad = (want.singular !== i_out_data.singular);
                    for (int k = 0; k < 10; k++) begin
                        w_exp = want[1 + W*(9-k) +: W];
                        w_got = i_out_data[1 + W*(9-k) +: W];
                        if (w_exp !== w_got) bad = 1;
                    end
                    if (bad) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch: expected %h", want);
                            $display("          got      %h", i_out_data);
                        end
                    end
                end
            end
        end
        pending = inv_q.size();
    end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the 3x3 inverse block.
// ----------------------------------------------------------------------------
// Directed matrices (zero, identity, extremes, singular, saturating) then
// random ones, mostly moderate-range with some full-range and singular.
// Both sides pause at random; one long output hold-off, a full drain mid-run and one at the end.
// ----------------------------------------------------------------------------
module tb import mi3_pkg::*; ();

    localparam int LIMIT = 200000;
    localparam int N_RAND = 1030;
    localparam logic [W-1:0] ONE = 32'h0001_0000;

    logic     i_clk = 0;
    logic     i_rst_n = 0;
    logic     i_valid = 0;
    logic     o_stall;
    t_mat_in  i_data = '0;
    logic     o_valid;
    logic     i_stall = 0;
    t_mat_out o_data;
    int       errors, pending;
    int       cycles = 0;
    bit       calm = 0;
    bit       hold_req = 0;

    matrix_inverse_3x3_top dut (.*);

    mi3_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_in_data(i_data),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_out_data(o_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // output side
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_req = 0;
            end
            i_stall <= !calm && ($urandom_range(99) < 10);
        end
    end

    task automatic send(t_mat_in d);
        logic s;
        i_valid <= 1'b1;
        i_data  <= d;
        forever begin
            @(negedge i_clk);
            s = o_stall;
            @(posedge i_clk);
            if (!s) break;
        end
        if (!calm && $urandom_range(99) < 10) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic logic [W-1:0] mod_val();
        return W'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    endfunction

    function automatic t_mat_in rand_mat();
        t_mat_in d;
        int sel;
        sel = $urandom_range(99);
        d = {$urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
        if (sel < 60) begin
            d = {mod_val(), mod_val(), mod_val(), mod_val(), mod_val(),
                 mod_val(), mod_val(), mod_val(), mod_val()};
        end else if (sel < 70) begin
            d.m20 = d.m00; d.m21 = d.m01; d.m22 = d.m02;
        end else if (sel < 80) begin
            d = {W'($urandom_range(0, 15)) - 8, W'($urandom_range(0, 15)) - 8,
                 W'($urandom_range(0, 15)) - 8, W'($urandom_range(0, 15)) - 8,
                 W'($urandom_range(0, 15)) - 8, W'($urandom_range(0, 15)) - 8,
                 W'($urandom_range(0, 15)) - 8, W'($urandom_range(0, 15)) - 8,
                 W'($urandom_range(0, 15)) - 8};
        end else if (sel < 85) begin
            d.m10 = '0; d.m20 = '0; d.m21 = '0;
        end
        return d;
    endfunction

    initial begin
        t_mat_in d;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send('0);
        send({ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE});
        send({-ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE});
        send({9{SMAX}});
        send({9{SMIN}});
        send({SMAX, 32'd0, 32'd0, 32'd0, SMAX, 32'd0, 32'd0, 32'd0, SMAX});
        send({SMIN, 32'd0, 32'd0, 32'd0, SMIN, 32'd0, 32'd0, 32'd0, SMIN});
        send({SMIN, 32'd0, 32'd0, 32'd0, SMAX, 32'd0, 32'd0, 32'd0, SMIN});
        send({32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1});
        send({-32'sd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1});
        send({ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE});
        send({ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE, 10 * ONE});
        send({32'd0, ONE, 32'd0, ONE, 32'd0, 32'd0, 32'd0, 32'd0, ONE});
        send({SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, SMIN});
        send({2 * ONE, 32'd0, 32'd0, 32'd0, 4 * ONE, 32'd0, 32'd0, 32'd0, 32'd0});
        send({32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0,
              32'd0, 32'd0, 32'hFFFF_FFFF});
        send({32'h100, 32'd0, 32'd0, 32'd0, 32'h100, 32'd0, 32'd0, 32'd0, 32'h100});

        for (int n = 0; n < N_RAND; n++) begin
            calm = (n >= 400 && n < 550);
            if (n == 200) hold_req = 1;
            if (n == 700) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
                wait (pending == 0);
                @(posedge i_clk);
            end
            d = rand_mat();
            send(d);
        end
        i_valid <= 1'b0;
        @(negedge i_clk);
        wait (pending == 0);
        repeat (LAT_TOT + 20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
